### sv/isrt_pkg.sv
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package isrt_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic ins;
        logic drain;
    } t_cell_ctl;

endpackage

`default_nettype wire

### sv/isrt_if.sv
// Handshake channels for input words and sorted result words.
`timescale 1ns / 1ps
`default_nettype none

interface isrt_in_if
    import isrt_pkg::*;
();
    logic  valid;
    logic  ready;
    t_data value;
    logic  final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface isrt_out_if
    import isrt_pkg::*;
();
    logic  valid;
    logic  ready;
    t_data sorted_value;
    logic  run_end;
    logic  overflowed;

    modport source (output valid, output sorted_value, output run_end, output overflowed,
                    input ready);
    modport sink   (input valid, input sorted_value, input run_end, input overflowed,
                    output ready);
endinterface

`default_nettype wire

### sv/insertion_sorter.sv
// Streaming insertion sorter built as a chain of compare-and-shift cells.
//
//   channel  dir  payload                                  accepted when
//   i_in     in   value[31:0] signed, final_item           valid && ready
//   o_out    out  sorted_value[31:0] signed, run_end,      valid && ready
//                 overflowed
//
// On an insert, every cell compares the word against its entry
// and the chain shifts right past the insertion point in the same edge.
// A word flagged final_item starts a drain that moves the chain left one
// cell per taken result and holds input off until the last entry of the run
// has been taken. Sink stalls hold the chain.
// Reset clears valid bits, drain state and the overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter
    import isrt_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    isrt_in_if.sink    i_in,
    isrt_out_if.source o_out
);

    t_data [CAPACITY-1:0] w_data;
    logic  [CAPACITY-1:0] w_valid;
    logic  [CAPACITY-1:0] w_lt;
    t_cell_ctl            w_ctl;
    logic                 r_drain;
    logic                 r_dropped;
    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_full;

    assign w_full    = w_valid[CAPACITY-1];
    assign i_in.ready = !r_drain;
    assign w_in_acc  = i_in.valid && !r_drain;
    assign w_out_acc = o_out.valid && o_out.ready;

    assign w_ctl.ins   = w_in_acc && !w_full;
    assign w_ctl.drain = w_out_acc;

    assign o_out.valid        = r_drain;
    assign o_out.sorted_value = w_data[0];
    assign o_out.run_end      = !w_valid[1];
    assign o_out.overflowed   = r_dropped;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data w_ld;
        logic  w_lv;
        logic  w_ll;
        t_data w_rd;
        logic  w_rv;

        if (g == 0) begin : g_first
            assign w_ld = '0;
            assign w_lv = 1'b1;
            assign w_ll = 1'b0;
        end else begin : g_mid_l
            assign w_ld = w_data[g-1];
            assign w_lv = w_valid[g-1];
            assign w_ll = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rd = '0;
            assign w_rv = 1'b0;
        end else begin : g_mid_r
            assign w_rd = w_data[g+1];
            assign w_rv = w_valid[g+1];
        end

        isrt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_value       (i_in.value),
            .i_left_data   (w_ld),
            .i_left_valid  (w_lv),
            .i_left_lt     (w_ll),
            .i_right_data  (w_rd),
            .i_right_valid (w_rv),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_lt          (w_lt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            if (w_in_acc && w_full) begin
                r_dropped <= 1'b1;
            end
            if (w_in_acc && i_in.final_item) begin
                r_drain <= 1'b1;
            end
            if (w_out_acc && o_out.run_end) begin
                r_drain   <= 1'b0;
                r_dropped <= 1'b0;
            end
        end
    end

    a_drain_has_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> w_valid[0])
        else $error("drain with empty chain");

    a_valid_prefix : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + CAPACITY'(1))) == '0)
        else $error("valid bits not contiguous");

    a_run_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.run_end) |=> (!r_drain && !r_dropped && !w_valid[0]))
        else $error("run end did not empty the chain");

    a_drop_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_full && !i_in.final_item) |=> r_dropped)
        else $error("dropped word not flagged");

endmodule

`default_nettype wire

### sv/isrt_cell.sv
// One cell of the sorting chain: holds one entry and its valid bit.
`timescale 1ns / 1ps
`default_nettype none

module isrt_cell
    import isrt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_data     i_value,
    input  wire t_data     i_left_data,
    input  wire logic      i_left_valid,
    input  wire logic      i_left_lt,
    input  wire t_data     i_right_data,
    input  wire logic      i_right_valid,
    output t_data          o_data,
    output logic           o_valid,
    output logic           o_lt
);

    t_data r_data;
    logic  r_valid;
    logic  w_take;

    assign o_lt   = r_valid && (i_value < r_data);
    assign w_take = o_lt || (!r_valid && i_left_valid);
    assign o_data  = r_data;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.drain) begin
            r_valid <= i_right_valid;
        end else if (i_ctl.ins && w_take) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.drain) begin
            r_data <= i_right_data;
        end else if (i_ctl.ins && w_take) begin
            r_data <= i_left_lt ? i_left_data : i_value;
        end
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for the insertion sorter: directed runs, then random runs with or without stalls.
`timescale 1ns / 1ps

module tb_top
    import isrt_pkg::*;
();

    localparam int unsigned SORT_DEPTH   = 32;
    localparam int unsigned WORD_TARGET  = 310;
    localparam int unsigned MAX_GAP      = 6;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned NUM_DIRECTED = 22;

    localparam t_data WORD_MIN = 32'sh8000_0000;
    localparam t_data WORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        t_data value;
        logic  run_end;
        logic  overflowed;
    } t_sorted_word;

    typedef struct packed {
        t_data value;
        logic  fin;
        logic  typed;
        t_data want_value;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n;

    isrt_in_if  in_ch ();
    isrt_out_if out_ch ();

    insertion_sorter #(
        .CAPACITY (SORT_DEPTH)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 clk = ~clk;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{WORD_MIN,       1'b1, 1'b1, WORD_MIN},
        '{WORD_MAX,       1'b1, 1'b1, WORD_MAX},
        '{32'sd0,         1'b1, 1'b1, 32'sd0},
        '{-32'sd1,        1'b1, 1'b1, -32'sd1},
        '{32'sd5,         1'b0, 1'b0, 32'sd0},
        '{-32'sd3,        1'b0, 1'b0, 32'sd0},
        '{32'sd5,         1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b0, 1'b0, 32'sd0},
        '{WORD_MIN,       1'b0, 1'b0, 32'sd0},
        '{WORD_MAX,       1'b0, 1'b0, 32'sd0},
        '{WORD_MIN,       1'b0, 1'b0, 32'sd0},
        '{WORD_MAX,       1'b0, 1'b0, 32'sd0},
        '{32'sd5,         1'b1, 1'b0, 32'sd0},
        '{32'sd3,         1'b0, 1'b0, 32'sd0},
        '{32'sd2,         1'b0, 1'b0, 32'sd0},
        '{32'sd1,         1'b1, 1'b0, 32'sd0},
        '{32'sd1,         1'b0, 1'b0, 32'sd0},
        '{32'sd2,         1'b0, 1'b0, 32'sd0},
        '{32'sd3,         1'b1, 1'b0, 32'sd0},
        '{32'sd7,         1'b0, 1'b0, 32'sd0},
        '{32'sd7,         1'b0, 1'b0, 32'sd0},
        '{32'sd7,         1'b1, 1'b0, 32'sd0}
    };

    t_data        held_words [SORT_DEPTH];
    int unsigned  held_n = 0;
    logic         held_dropped = 1'b0;
    t_sorted_word pending_sorted [$];

    logic        word_typed;
    t_data       word_expect;
    bit          calm = 1'b0;
    int unsigned words_sent = 0;
    int unsigned words_in = 0;
    int unsigned words_out = 0;
    int unsigned runs_done = 0;
    int unsigned runs_over = 0;
    int unsigned errs = 0;
    int unsigned idle_cycles = 0;

    task automatic place_word(input t_data v, input logic fin, input logic typed,
                              input t_data want_value);
        int unsigned pos;
        if (held_n >= SORT_DEPTH) begin
            held_dropped = 1'b1;
        end else begin
            pos = held_n;
            while (pos > 0 && v < held_words[pos-1]) pos--;
            for (int unsigned i = held_n; i > pos; i--) held_words[i] = held_words[i-1];
            held_words[pos] = v;
            held_n++;
        end
        if (fin) begin
            runs_done++;
            if (held_dropped) runs_over++;
            if (typed) begin
                pending_sorted.push_back(t_sorted_word'{want_value, 1'b1, 1'b0});
            end else begin
                for (int unsigned k = 0; k < held_n; k++)
                    pending_sorted.push_back(
                        t_sorted_word'{held_words[k], k + 1 == held_n, held_dropped});
            end
            held_n       = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic send_word(input t_data v, input logic fin, input logic typed,
                             input t_data want_value);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= v;
        in_ch.final_item <= fin;
        word_typed       <= typed;
        word_expect      <= want_value;
        do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
        words_sent++;
    endtask

    // hold input off until every sorted word has come back
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_sorted.size() != 0) @(posedge clk);
    endtask

    function automatic int unsigned pick_run_len(input int unsigned run_no);
        int unsigned r;
        if (run_no == 0) return SORT_DEPTH;
        if (run_no == 1) return SORT_DEPTH + 3;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 8);
        if (r < 3) return $urandom_range(9, SORT_DEPTH - 1);
        return $urandom_range(1, 8);
    endfunction

    function automatic t_data pick_value();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 5))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return WORD_MIN + 1;
                    3: return WORD_MAX - 1;
                    4: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return t_data'($signed($urandom_range(0, 8)) - 4);
            default: return t_data'($urandom());
        endcase
    endfunction

    always @(posedge clk) begin : check_b
        t_sorted_word want;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                words_in++;
                place_word(in_ch.value, in_ch.final_item, word_typed, word_expect);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_sorted.size() == 0) begin
                    errs++;
                    $error("sorted_value: expected none, got %0d", out_ch.sorted_value);
                end else begin
                    want = pending_sorted.pop_front();
                    words_out++;
                    if (out_ch.sorted_value !== want.value) begin
                        errs++;
                        $error("sorted_value: expected %0d, got %0d",
                               want.value, out_ch.sorted_value);
                    end
                    if (out_ch.run_end !== want.run_end) begin
                        errs++;
                        $error("run_end: expected %0b, got %0b", want.run_end, out_ch.run_end);
                    end
                    if (out_ch.overflowed !== want.overflowed) begin
                        errs++;
                        $error("overflowed: expected %0b, got %0b",
                               want.overflowed, out_ch.overflowed);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : sink_b
        int unsigned stall;
        out_ch.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin : source_b
        int unsigned run_len;
        int unsigned run_no;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.final_item = 1'b0;
        word_typed       = 1'b0;
        word_expect      = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_word(directed_rows[r].value, directed_rows[r].fin,
                      directed_rows[r].typed, directed_rows[r].want_value);
        hold_until_drained();

        run_no = 0;
        while (words_sent < WORD_TARGET) begin
            run_len = pick_run_len(run_no);
            if ($urandom_range(0, 4) == 0) calm = !calm;
            for (int unsigned n = 1; n <= run_len; n++)
                send_word(pick_value(), n == run_len, 1'b0, '0);
            if ($urandom_range(0, 9) == 0) hold_until_drained();
            run_no++;
        end

        calm = 1'b0;
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d words sent in %0d runs, %0d of them past capacity",
                 words_in, runs_done, runs_over);
        $display("tb_top: %0d sorted words checked, %0d left waiting",
                 words_out, pending_sorted.size());
        if (errs == 0 && pending_sorted.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

### files.f
sv/isrt_pkg.sv
sv/isrt_if.sv
sv/isrt_cell.sv
sv/insertion_sorter.sv
sim/tb_top.sv
